FILE: hdl/tap_pkg.sv
// Shared constants for the triangle area/perimeter core.
// No dependencies.
`default_nettype none
package tap_pkg;
    localparam int AREA_W  = 33;
    localparam int PERIM_W = 27;
    localparam int NUM_EDGES = 3;
endpackage
`default_nettype wire

FILE: hdl/tap_edge_lane.sv
// One edge lane: squared distance, then a pipelined integer square root.
// Depends on nothing but its parameters.
`default_nettype none
module tap_edge_lane #(
    parameter int CW = 16,
    parameter int FB = 8,
    parameter int RW = CW + 1 + FB
) (
    input  wire logic                 i_clk,
    input  wire logic signed [CW-1:0] i_x0,
    input  wire logic signed [CW-1:0] i_y0,
    input  wire logic signed [CW-1:0] i_x1,
    input  wire logic signed [CW-1:0] i_y1,
    output logic [RW-1:0]             o_len
);
    localparam int DW = CW + 1;
    localparam int SW = 2 * DW + 1;
    localparam int VW = SW + 2 * FB;
    localparam int NS = VW / 2 + VW % 2;

    logic signed [DW-1:0] r_dx, r_dy;
    logic [2*DW-1:0] r_px, r_py;
    logic [VW-1:0] r_v [0:NS-1];
    logic [RW-1:0] r_q [0:NS];

    always_ff @(posedge i_clk) begin
        r_dx <= DW'(i_x0) - DW'(i_x1);
        r_dy <= DW'(i_y0) - DW'(i_y1);
        r_px <= (2*DW)'(r_dx * r_dx);
        r_py <= (2*DW)'(r_dy * r_dy);
        r_v[0] <= VW'({1'b0, r_px} + {1'b0, r_py}) << (2 * FB);
        r_q[0] <= '0;
    end

    // One result bit per stage, restoring method.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int SH = 2 * (NS - 1 - s);
        logic [VW+1:0] trial;
        logic [VW+1:0] rem;
        logic          take;
        always_comb begin
            trial = ({2'b0, r_v[s]} >> SH);
            rem   = {(VW+2){1'b0}} | ({r_q[s], 2'b01});
            take  = trial >= rem;
        end
        always_ff @(posedge i_clk) begin
            r_q[s+1] <= RW'({r_q[s], take});
        end
        if (s < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (take) begin
                    r_v[s+1] <= r_v[s] - VW'(rem << SH);
                end else begin
                    r_v[s+1] <= r_v[s];
                end
            end
        end
    end

    assign o_len = r_q[NS];
endmodule
`default_nettype wire

FILE: hdl/tap_det_unit.sv
// Determinant pipeline: differences, products, sum, absolute value.
// Depends on tap_pkg.
`default_nettype none
module tap_det_unit import tap_pkg::*; #(
    parameter int CW = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic signed [CW-1:0] i_ax, i_ay, i_bx, i_by, i_cx, i_cy,
    output logic                      o_real,
    output logic [AREA_W-1:0]         o_mag
);
    localparam int DW = CW + 1;
    localparam int PW = CW + DW;
    localparam int TW = PW + 2;

    logic signed [CW-1:0] r_ax, r_bx, r_cx;
    logic signed [DW-1:0] r_d0, r_d1, r_d2;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [TW-1:0] r_det;
    logic                 r_rl [0:DEPTH];
    logic [AREA_W-1:0]    r_mg [0:DEPTH];
    logic [TW-1:0]        n_abs;

    always_comb n_abs = r_det[TW-1] ? TW'(-r_det) : TW'(r_det);

    always_ff @(posedge i_clk) begin
        r_ax <= i_ax; r_bx <= i_bx; r_cx <= i_cx;
        r_d0 <= DW'(i_by) - DW'(i_cy);
        r_d1 <= DW'(i_cy) - DW'(i_ay);
        r_d2 <= DW'(i_ay) - DW'(i_by);
        r_p0 <= PW'(r_ax * r_d0);
        r_p1 <= PW'(r_bx * r_d1);
        r_p2 <= PW'(r_cx * r_d2);
        r_det <= TW'(r_p0) + TW'(r_p1) + TW'(r_p2);
        r_rl[0] <= r_det != '0;
        r_mg[0] <= AREA_W'(n_abs);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_rl[k+1] <= r_rl[k];
            r_mg[k+1] <= r_mg[k];
        end
    end

    assign o_real = r_rl[DEPTH];
    assign o_mag  = r_mg[DEPTH];
endmodule
`default_nettype wire

FILE: hdl/triangle_area_perimeter_core.sv
// Top level: determinant unit, edge lanes for sides AB, BC and CA, merge stage.
// Depends on tap_pkg, tap_det_unit, tap_edge_lane.
// The result latency is set by the COORD_WIDTH + FRAC_BITS + 2 stage square root
// pipeline in each edge lane.
// Throughput: one word per cycle; busy is low except in reset. Receiver cannot stall.
// Reset clears only the result strobe pipeline.
`default_nettype none
module triangle_area_perimeter_core import tap_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy,
    output logic                               o_valid,
    output logic                               o_is_real_triangle,
    output logic [AREA_W-1:0]                  o_double_area,
    output logic [PERIM_W-1:0]                 o_perimeter,
    output logic                               o_is_equilateral
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int VW = 2 * DW + 1 + 2 * FRAC_BITS;
    localparam int NS = VW / 2 + VW % 2;
    localparam int RW = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int LAT = NS + 3;

    logic [RW-1:0] w_len [NUM_EDGES];
    logic w_real;
    logic [AREA_W-1:0] w_mag;
    logic [LAT:0] r_vld;

    assign busy = ~i_rst_n;

    tap_det_unit #(.CW(COORD_WIDTH), .DEPTH(NS - 1)) u_det (
        .i_clk, .i_ax, .i_ay, .i_bx, .i_by(i_by_coord), .i_cx, .i_cy,
        .o_real(w_real), .o_mag(w_mag));

    tap_edge_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .RW(RW)) u_e0 (
        .i_clk, .i_x0(i_ax), .i_y0(i_ay), .i_x1(i_bx), .i_y1(i_by_coord), .o_len(w_len[0]));
    tap_edge_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .RW(RW)) u_e1 (
        .i_clk, .i_x0(i_bx), .i_y0(i_by_coord), .i_x1(i_cx), .i_y1(i_cy), .o_len(w_len[1]));
    tap_edge_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .RW(RW)) u_e2 (
        .i_clk, .i_x0(i_cx), .i_y0(i_cy), .i_x1(i_ax), .i_y1(i_ay), .o_len(w_len[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-1:0], start};
        o_is_real_triangle <= w_real;
        o_double_area      <= w_mag;
        o_perimeter        <= w_real ? PERIM_W'(RW'(w_len[0]) + RW'(w_len[1])
                                          + (RW+2)'(w_len[2]) + (RW+2)'(0)) : '0;
        o_is_equilateral   <= w_real && (w_len[0] == w_len[1]) && (w_len[1] == w_len[2]);
    end

    assign o_valid = r_vld[LAT];
endmodule
`default_nettype wire

FILE: sim/tb_triangle_area_perimeter_core.sv
// Self-checking testbench for triangle_area_perimeter_core: a directed table, then random
// triangles in three idle regimes, checked against typed-in rows or an in-bench predictor.
// Depends on tap_pkg and triangle_area_perimeter_core.
`default_nettype none
module tb_triangle_area_perimeter_core import tap_pkg::*; ();

    localparam int CW        = 16;
    localparam int FB        = 8;
    localparam int WDOG_MAX  = 5000;
    localparam int TAIL_CYC  = 40;
    localparam int ITEMS_PER = 550;

    typedef struct packed {
        logic             real_tri;
        logic [AREA_W-1:0]  area2;
        logic [PERIM_W-1:0] perim;
        logic             equi;
    } meas_t;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
        logic                 typed;
        meas_t                want;
    } tri_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by_coord = '0, i_cx = '0, i_cy = '0;
    logic o_valid, o_is_real_triangle, o_is_equilateral;
    logic [AREA_W-1:0]  o_double_area;
    logic [PERIM_W-1:0] o_perimeter;

    logic  row_typed = 1'b0;
    meas_t row_want  = '0;

    meas_t meas_q[$];
    bit    failed = 1'b0;
    int    idle_cnt = 0;

    triangle_area_perimeter_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy),
        .o_valid(o_valid), .o_is_real_triangle(o_is_real_triangle),
        .o_double_area(o_double_area), .o_perimeter(o_perimeter),
        .o_is_equilateral(o_is_equilateral)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned edge_fix(longint x0, longint y0, longint x1, longint y1);
        longint dx;
        longint dy;
        longint unsigned d2;
        dx = x0 - x1;
        dy = y0 - y1;
        d2 = dx * dx + dy * dy;
        return int_sqrt(d2 << (2 * FB));
    endfunction

    function automatic meas_t tri_measure(logic signed [CW-1:0] ax, ay, bx, by, cx, cy);
        longint a_x, a_y, b_x, b_y, c_x, c_y, det, mag;
        longint unsigned l1, l2, l3;
        meas_t m;
        a_x = ax; a_y = ay; b_x = bx; b_y = by; c_x = cx; c_y = cy;
        det = a_x * (b_y - c_y) + b_x * (c_y - a_y) + c_x * (a_y - b_y);
        mag = (det < 0) ? -det : det;
        m = '0;
        m.real_tri = (det != 0);
        m.area2 = mag[AREA_W-1:0];
        if (det != 0) begin
            l1 = edge_fix(a_x, a_y, b_x, b_y);
            l2 = edge_fix(b_x, b_y, c_x, c_y);
            l3 = edge_fix(c_x, c_y, a_x, a_y);
            m.perim = PERIM_W'(l1 + l2 + l3);
            m.equi = (l1 == l2) && (l2 == l3);
        end
        return m;
    endfunction

    always @(posedge i_clk) begin
        meas_t w;
        if (i_rst_n && o_valid) begin
            if (meas_q.size() == 0) begin
                $display("%0t: unexpected word real=%b area=%0d perim=%0d equi=%b", $time,
                         o_is_real_triangle, o_double_area, o_perimeter, o_is_equilateral);
                failed = 1'b1;
            end else begin
                w = meas_q.pop_front();
                if (w.real_tri !== o_is_real_triangle) begin
                    $display("%0t: real_triangle exp %b got %b", $time, w.real_tri,
                             o_is_real_triangle);
                    failed = 1'b1;
                end
                if (w.area2 !== o_double_area) begin
                    $display("%0t: double_area exp %0d got %0d", $time, w.area2, o_double_area);
                    failed = 1'b1;
                end
                if (w.perim !== o_perimeter) begin
                    $display("%0t: perimeter exp %0d got %0d", $time, w.perim, o_perimeter);
                    failed = 1'b1;
                end
                if (w.equi !== o_is_equilateral) begin
                    $display("%0t: equilateral exp %b got %b", $time, w.equi, o_is_equilateral);
                    failed = 1'b1;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            if (row_typed) meas_q.push_back(row_want);
            else meas_q.push_back(tri_measure(i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy));
        end
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cnt = 0;
        else idle_cnt = idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("triangle_area_perimeter_core verification failed");
            $finish;
        end
    end

    task automatic send_tri(tri_row_t r, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        i_ax = r.ax; i_ay = r.ay; i_bx = r.bx; i_by_coord = r.by; i_cx = r.cx; i_cy = r.cy;
        row_typed = r.typed;
        row_want = r.want;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(int kind);
        case (kind)
            0: return CW'($urandom);
            1: return CW'($urandom_range(16)) - 16'sd8;
            default: return CW'($urandom_range(400)) - 16'sd200;
        endcase
    endfunction

    function automatic tri_row_t rnd_tri();
        tri_row_t r;
        int k, kind, s, t;
        logic signed [CW-1:0] dx, dy, n;
        r = '0;
        k = $urandom_range(9);
        kind = $urandom_range(2);
        r.ax = rnd_coord(kind); r.ay = rnd_coord(kind);
        r.bx = rnd_coord(kind); r.by = rnd_coord(kind);
        r.cx = rnd_coord(kind); r.cy = rnd_coord(kind);
        if (k == 5) begin
            dx = rnd_coord(1); dy = rnd_coord(1);
            s = $urandom_range(20); t = $urandom_range(20);
            r.bx = r.ax + dx * s; r.by = r.ay + dy * s;
            r.cx = r.ax - dx * t; r.cy = r.ay - dy * t;
        end else if (k == 6) begin
            r.bx = r.ax; r.by = r.ay;
        end else if (k == 7) begin
            n = $urandom_range(1, 2000);
            r.ax = rnd_coord(2); r.ay = rnd_coord(2);
            r.bx = r.ax + 2 * n; r.by = r.ay;
            r.cx = r.ax + n; r.cy = r.ay + CW'((n * 1732 + $urandom_range(2) * 500) / 1000);
        end else if (k == 8) begin
            r.ax = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            r.cy = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        return r;
    endfunction

    initial begin
        tri_row_t dir_tab[];
        dir_tab = '{
            '{ax: 0, ay: 0, bx: 0, by: 0, cx: 0, cy: 0, typed: 1, want: '0},
            '{ax: -32768, ay: -32768, bx: -32768, by: -32768, cx: -32768, cy: -32768,
              typed: 1, want: '0},
            '{ax: 32767, ay: 32767, bx: 32767, by: 32767, cx: 32767, cy: 32767,
              typed: 1, want: '0},
            '{ax: 0, ay: 0, bx: 3, by: 0, cx: 0, cy: 4, typed: 1, want: '{1, 12, 3072, 0}},
            '{ax: 0, ay: 0, bx: 1, by: 0, cx: 0, cy: 1, typed: 1, want: '{1, 1, 874, 0}},
            '{ax: 0, ay: 0, bx: 0, by: 1, cx: 1, cy: 0, typed: 1, want: '{1, 1, 874, 0}},
            '{ax: 1, ay: 1, bx: 2, by: 2, cx: 3, cy: 3, typed: 1, want: '0},
            '{ax: 5, ay: 5, bx: 5, by: 5, cx: 9, cy: 1, typed: 1, want: '0},
            '{ax: -32768, ay: -32768, bx: 32767, by: -32768, cx: -32768, cy: 32767,
              typed: 1, want: '{1, 33'd4294836225, 0, 0}},
            '{ax: 32767, ay: 32767, bx: -32768, by: -32768, cx: 32767, cy: -32768,
              typed: 0, want: '0},
            '{ax: -32768, ay: 32767, bx: 32767, by: -32768, cx: 0, cy: 0, typed: 0, want: '0},
            '{ax: -1, ay: -1, bx: 32767, by: -32768, cx: -32768, cy: 32767, typed: 0, want: '0},
            '{ax: 0, ay: 0, bx: 112, by: 0, cx: 56, cy: 97, typed: 0, want: '0},
            '{ax: -5, ay: 7, bx: 100, by: -3, cx: 40, cy: 90, typed: 0, want: '0}
        };
        // extreme row: perimeter from the predictor, area typed in
        dir_tab[8].want.perim = tri_measure(-32768, -32768, 32767, -32768, -32768, 32767).perim;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_tab[i]) send_tri(dir_tab[i], 20);
        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < ITEMS_PER; n++)
                send_tri(rnd_tri(), (ph == 0) ? 30 : (ph == 1) ? 88 : 0);
            if (ph == 0) begin
                @(negedge i_clk);
                start = 1'b0;
                while (meas_q.size() != 0) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        start = 1'b0;
        row_typed = 1'b0;
        while (meas_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);
        if (!failed && meas_q.size() == 0) begin
            $display("triangle_area_perimeter_core verification clean");
        end else begin
            $display("triangle_area_perimeter_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
